// ----- rtl/compressor_sensor_event_detector_macros.svh -----
// assertion macros used by the checker file
`ifndef COMPRESSOR_SENSOR_EVENT_DETECTOR_MACROS_SVH
`define COMPRESSOR_SENSOR_EVENT_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CSED_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csed assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define CSED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csed assertion failed");

`endif

// ----- rtl/csed_pkg.sv -----
// shared types and constants of the compressor sensor event detector
`timescale 1ns / 1ps

package csed_pkg;

    // converter code width and full scale
    localparam int SAMPLE_BITS = 12;
    localparam int FULL_SCALE  = 1 << SAMPLE_BITS;

    // result widths
    localparam int PRESS_W = 10;
    localparam int CUR_W   = 10;

    // pressure front end: a = 13200*s - 3999*FS, taken as t = a / 48
    localparam int PRESS_GAIN   = 275;
    localparam int PRESS_OFFSET = 3999 * FULL_SCALE / 48;
    localparam int PRESS_T_MIN  = 889 * FULL_SCALE / 16;   // magnitude at 0.333 V
    localparam int PRESS_T_MAX  = 3 * PRESS_T_MIN;         // value at 3.0 V
    localparam int T_W          = SAMPLE_BITS + 9;         // 275*s
    localparam int Y_W          = SAMPLE_BITS + 8;         // |t|

    // psi factor times 1e8, split for the constant multiply
    localparam longint unsigned PSI_K   = 64'd14503773779;
    localparam int              K_SPLIT = 17;
    localparam longint unsigned PSI_K_HI = PSI_K >> K_SPLIT;
    localparam longint unsigned PSI_K_LO = PSI_K & ((64'd1 << K_SPLIT) - 64'd1);

    // divisor E = 2667*FS*1e8/48; 2E = DIV_D * 2^DIV_SHIFT
    localparam longint unsigned PSI_E = 64'd889 * (FULL_SCALE / 16) * 64'd100000000;
    localparam int              DIV_SHIFT = SAMPLE_BITS + 5;
    localparam longint unsigned DIV_D     = 64'd347265625;
    localparam int              N_W = Y_W + 36;            // 2*y*K + E
    localparam int              M_W = 38;                  // (2*y*K + E) >> DIV_SHIFT

    // quotient estimate from the top bits of m, never above the true quotient
    localparam int              EST_IN_W  = 18;
    localparam int              EST_DROP  = M_W - EST_IN_W;
    localparam int              EST_FRAC  = 24;
    localparam int              EST_P_W   = EST_IN_W + 16;
    localparam longint unsigned EST_RECIP = (64'd1 << (EST_DROP + EST_FRAC)) / DIV_D;
    localparam int              Q_W       = 9;

    // current scale: tenths = round(625*c / FS)
    localparam int CUR_GAIN = 625;
    localparam int CUR_P_W  = SAMPLE_BITS + 10;

    typedef logic [SAMPLE_BITS-1:0]    sample_t;
    typedef logic signed [PRESS_W-1:0] press_t;
    typedef logic [CUR_W-1:0]          cur_t;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } csed_adv_t;

endpackage

// ----- rtl/csed_pressure.sv -----
// pressure conversion pipeline: clamp, psi scale and rounded constant divide
`timescale 1ns / 1ps

module csed_pressure (
    input  logic                clk,
    input  csed_pkg::csed_adv_t adv,
    input  csed_pkg::sample_t   sample,
    output csed_pkg::press_t    tenths
);
    import csed_pkg::*;

    logic             neg1_reg, neg1_next;
    logic [Y_W-1:0]   y1_reg, y1_next;
    logic             neg2_reg;
    logic [M_W-1:0]   m2_reg, m2_next;
    logic             neg3_reg;
    logic [M_W-1:0]   m3_reg;
    logic [Q_W-1:0]   qe3_reg, qe3_next;

    logic [T_W-1:0]         gain_prod;
    logic signed [T_W:0]    t_val;
    logic [N_W-1:0]         n_prod;
    logic [N_W-1:0]         n_val;
    logic [EST_IN_W-1:0]    est_in;
    logic [EST_P_W-1:0]     est_prod;
    logic [M_W-1:0]         qd;
    logic [M_W-1:0]         rem;
    logic [Q_W-1:0]         q_val;
    logic signed [PRESS_W-1:0] mag;

    // stage 1: linear map and clamp, split into sign and magnitude
    always_comb
    begin
        gain_prod = T_W'(sample) * T_W'(PRESS_GAIN);
        t_val     = $signed({1'b0, gain_prod}) - $signed((T_W + 1)'(PRESS_OFFSET));
        if (t_val < -$signed((T_W + 1)'(PRESS_T_MIN)))
        begin
            neg1_next = 1'b1;
            y1_next   = Y_W'(PRESS_T_MIN);
        end
        else if (t_val > $signed((T_W + 1)'(PRESS_T_MAX)))
        begin
            neg1_next = 1'b0;
            y1_next   = Y_W'(PRESS_T_MAX);
        end
        else if (t_val < 0)
        begin
            neg1_next = 1'b1;
            y1_next   = Y_W'(-t_val);
        end
        else
        begin
            neg1_next = 1'b0;
            y1_next   = Y_W'(t_val);
        end
    end

    // stage 2: 2*y*K + E, low bits dropped since 2E carries that power of two
    always_comb
    begin
        n_prod  = ((N_W'(y1_reg) * N_W'(PSI_K_HI)) << K_SPLIT) + N_W'(y1_reg) * N_W'(PSI_K_LO);
        n_val   = (n_prod << 1) + N_W'(PSI_E);
        m2_next = n_val[DIV_SHIFT +: M_W];
    end

    // stage 3: quotient estimate by reciprocal, off by at most one low
    always_comb
    begin
        est_in   = m2_reg[M_W-1 -: EST_IN_W];
        est_prod = EST_P_W'(est_in) * EST_P_W'(EST_RECIP);
        qe3_next = est_prod[EST_FRAC +: Q_W];
    end

    // stage 4: remainder check fixes the estimate, then restore the sign
    always_comb
    begin
        qd     = M_W'(qe3_reg) * M_W'(DIV_D);
        rem    = m3_reg - qd;
        q_val  = qe3_reg + Q_W'(rem >= M_W'(DIV_D));
        mag    = $signed({1'b0, q_val});
        tenths = neg3_reg ? -mag : mag;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            neg1_reg <= neg1_next;
            y1_reg   <= y1_next;
        end
        if (adv.s2)
        begin
            neg2_reg <= neg1_reg;
            m2_reg   <= m2_next;
        end
        if (adv.s3)
        begin
            neg3_reg <= neg2_reg;
            m3_reg   <= m2_reg;
            qe3_reg  <= qe3_next;
        end
    end

endmodule

// ----- rtl/compressor_sensor_event_detector.sv -----
// top level: sensor conversion pipeline, event flags and result register
`timescale 1ns / 1ps

// Takes one pressure/current sample pair per beat and returns one result beat
// per pair: pressure in tenths of psi, motor current in tenths of amps, and
// the motor, pressure-change and supply event flags with the pressurized flag.
// A new pair can be accepted every cycle while results are taken. Each pair
// passes an input stage, three arithmetic stages and the result register; that
// depth is set by the pressure path, which scales by the psi factor and divides
// by a constant with exact half-away rounding.
// Each stage holds only when the stage after it is full and stalled, so input
// keeps flowing while a result waits, as long as there is a free stage.
// Event flags compare against the previous result delivered into the result
// register; reset clears the previous values and the pressurized flag.
module compressor_sensor_event_detector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csed_pkg::sample_t   pressure_sample,
    input  csed_pkg::sample_t   current_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output csed_pkg::press_t    pressure_tenths,
    output csed_pkg::cur_t      current_tenths,
    output logic                motor_started,
    output logic                motor_stopped,
    output logic                pressure_changed,
    output logic                supply_started,
    output logic                supply_stopped,
    output logic                pressurized_now
);
    import csed_pkg::*;

    // stage valids and result valid
    logic v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic out_valid_reg, out_valid_next;

    // input and current datapath registers
    sample_t p_in_reg, c_in_reg;
    cur_t    cur1_reg, cur1_next, cur2_reg, cur3_reg;

    // event state
    press_t  prev_press_reg, prev_press_next;
    cur_t    prev_cur_reg, prev_cur_next;
    logic    pressurized_reg, pressurized_next;

    // result register
    press_t  press_out_reg;
    cur_t    cur_out_reg;
    logic    m_start_reg, m_stop_reg, changed_reg, s_start_reg, s_stop_reg, flag_out_reg;

    logic       ld_out, ld3, ld2, ld1, fire;
    csed_adv_t  adv;
    press_t     press_val;
    logic [SAMPLE_BITS-1:0] c_span;
    logic [CUR_P_W-1:0]     cur_prod;
    logic       m_start, m_stop, changed, s_start, s_stop;

    // stall chain: a stage loads when it is empty or its successor moves
    always_comb
    begin
        ld_out   = !out_valid_reg || out_ready;
        ld3      = !v3_reg || ld_out;
        ld2      = !v2_reg || ld3;
        ld1      = !v1_reg || ld2;
        in_ready = !v0_reg || ld1;
        fire     = v3_reg && ld_out;
        adv.s1   = ld1;
        adv.s2   = ld2;
        adv.s3   = ld3;
    end

    always_comb
    begin
        v0_next        = in_ready ? in_valid : v0_reg;
        v1_next        = ld1 ? v0_reg : v1_reg;
        v2_next        = ld2 ? v1_reg : v2_reg;
        v3_next        = ld3 ? v2_reg : v3_reg;
        out_valid_next = ld_out ? v3_reg : out_valid_reg;
    end

    // pressure path
    csed_pressure u_pressure (
        .clk    (clk),
        .adv    (adv),
        .sample (p_in_reg),
        .tenths (press_val)
    );

    // current: clamp to the upper half of the scale, then round(625*c / FS)
    always_comb
    begin
        c_span    = c_in_reg[SAMPLE_BITS-1] ? {c_in_reg[SAMPLE_BITS-2:0], 1'b0} : '0;
        cur_prod  = CUR_P_W'(c_span) * CUR_P_W'(CUR_GAIN) + CUR_P_W'(FULL_SCALE / 2);
        cur1_next = cur_prod[SAMPLE_BITS +: CUR_W];
    end

    // event flags against the previous result
    always_comb
    begin
        m_start          = (cur3_reg != '0) && (prev_cur_reg == '0);
        m_stop           = (cur3_reg == '0) && (prev_cur_reg != '0);
        changed          = (press_val != prev_press_reg);
        s_start          = 1'b0;
        s_stop           = 1'b0;
        pressurized_next = pressurized_reg;
        priority if (press_val > prev_press_reg)
        begin
            s_stop = pressurized_reg;
        end
        else if (prev_press_reg > press_val)
        begin
            if (press_val == '0)
                pressurized_next = 1'b0;
            else
                s_start = pressurized_reg;
        end
        else if (!pressurized_reg && (press_val > 0))
        begin
            pressurized_next = 1'b1;
        end
        else
        begin
            pressurized_next = pressurized_reg;
        end
        prev_press_next = press_val;
        prev_cur_next   = cur3_reg;
    end

    // control and event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_press_reg  <= '0;
            prev_cur_reg    <= '0;
            pressurized_reg <= 1'b0;
        end
        else
        begin
            v0_reg        <= v0_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                prev_press_reg  <= prev_press_next;
                prev_cur_reg    <= prev_cur_next;
                pressurized_reg <= pressurized_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            p_in_reg <= pressure_sample;
            c_in_reg <= current_sample;
        end
        if (ld1)
            cur1_reg <= cur1_next;
        if (ld2)
            cur2_reg <= cur1_reg;
        if (ld3)
            cur3_reg <= cur2_reg;
        if (fire)
        begin
            press_out_reg <= press_val;
            cur_out_reg   <= cur3_reg;
            m_start_reg   <= m_start;
            m_stop_reg    <= m_stop;
            changed_reg   <= changed;
            s_start_reg   <= s_start;
            s_stop_reg    <= s_stop;
            flag_out_reg  <= pressurized_next;
        end
    end

    // result ports
    assign out_valid        = out_valid_reg;
    assign pressure_tenths  = press_out_reg;
    assign current_tenths   = cur_out_reg;
    assign motor_started    = m_start_reg;
    assign motor_stopped    = m_stop_reg;
    assign pressure_changed = changed_reg;
    assign supply_started   = s_start_reg;
    assign supply_stopped   = s_stop_reg;
    assign pressurized_now  = flag_out_reg;

endmodule

// ----- rtl/csed_checker.sv -----
// port-level checker for the event detector and its bind
`timescale 1ns / 1ps
`include "compressor_sensor_event_detector_macros.svh"

module csed_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input csed_pkg::press_t    pressure_tenths,
    input csed_pkg::cur_t      current_tenths,
    input logic                motor_started,
    input logic                motor_stopped,
    input logic                pressure_changed,
    input logic                supply_started,
    input logic                supply_stopped,
    input logic                pressurized_now
);

    logic                                           out_stall;
    logic [csed_pkg::PRESS_W + csed_pkg::CUR_W + 5:0] out_beat;
    logic                                           in_range;
    logic                                           motor_ok;
    logic                                           supply_ok;

    // stalled result beat and its whole payload
    assign out_stall = out_valid && !out_ready;
    assign out_beat  = {pressure_tenths, current_tenths, motor_started, motor_stopped,
                        pressure_changed, supply_started, supply_stopped, pressurized_now};

    // clamped ranges and flag consistency
    assign in_range  = (pressure_tenths >= -10'sd145) && (pressure_tenths <= 10'sd435)
                       && (current_tenths <= 10'd625);
    assign motor_ok  = motor_started ? (current_tenths != 10'd0) : (current_tenths == 10'd0);
    assign supply_ok = pressure_changed && !(supply_started && supply_stopped);

    // a stalled result beat stays offered and unchanged
    `CSED_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
    `CSED_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_beat))

    // results stay inside the clamped ranges
    `CSED_ASSERT_NOW(a_range, out_valid, in_range)

    // a motor start needs current and a motor stop needs none
    `CSED_ASSERT_NOW(a_motor, out_valid && (motor_started || motor_stopped), motor_ok)

    // supply events only come with a pressure change, and never both at once
    `CSED_ASSERT_NOW(a_supply, out_valid && (supply_started || supply_stopped), supply_ok)

endmodule

bind compressor_sensor_event_detector csed_checker u_csed_checker (.*);

// ----- bench/tb.sv -----
// self-checking testbench for the compressor sensor event detector
`timescale 1ns / 1ps

module tb;
    import csed_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASE_ITEMS  = 150;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int PLAN_ROWS    = 22;

    // pressure clamp points and span, scaled by 1000 * full scale
    localparam longint V_LO_SCALED = 333 * FULL_SCALE;
    localparam longint V_HI_SCALED = 3000 * FULL_SCALE;
    localparam longint SPAN_SCALED = 2667 * FULL_SCALE;
    // psi factor times 1e8 and the matching divisor
    localparam longint unsigned PSI_TIMES_1E8 = 64'd14503773779;
    localparam longint unsigned PSI_DIVISOR   = 64'd2667 * FULL_SCALE * 64'd100000000;
    localparam longint unsigned FS_U          = FULL_SCALE;

    typedef struct packed {
        press_t pressure;
        cur_t   current;
        logic   motor_on;
        logic   motor_off;
        logic   press_moved;
        logic   supply_on;
        logic   supply_off;
        logic   press_held;
    } reading_t;

    typedef struct packed {
        sample_t  ps;
        sample_t  cs;
        logic     typed;
        reading_t want;
    } plan_row_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    sample_t pressure_sample;
    sample_t current_sample;
    logic    out_valid;
    logic    out_ready;
    press_t  pressure_tenths;
    cur_t    current_tenths;
    logic    motor_started;
    logic    motor_stopped;
    logic    pressure_changed;
    logic    supply_started;
    logic    supply_stopped;
    logic    pressurized_now;

    // predictor state and bookkeeping
    reading_t  expected_readings[$];
    int        last_pressure;
    int        last_current;
    logic      pressurized;
    int        errors = 0;
    int        beats_out = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    logic      idle_on;
    plan_row_t plan [PLAN_ROWS];

    compressor_sensor_event_detector uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pressure_sample  (pressure_sample),
        .current_sample   (current_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pressure_tenths  (pressure_tenths),
        .current_tenths   (current_tenths),
        .motor_started    (motor_started),
        .motor_stopped    (motor_stopped),
        .pressure_changed (pressure_changed),
        .supply_started   (supply_started),
        .supply_stopped   (supply_stopped),
        .pressurized_now  (pressurized_now)
    );

    always #1 clk = ~clk;

    // converts one sample pair and updates the event state
    function automatic reading_t predict_reading(input sample_t ps, input sample_t cs);
        longint            volt;
        longint            a;
        longint            amps;
        longint unsigned   mag;
        longint unsigned   q;
        longint unsigned   r;
        longint unsigned   num;
        int                p;
        int                c;
        reading_t          rd;
        // pressure: clamp the voltage, map to kPa around zero, scale to tenths of psi
        volt = longint'(ps) * 3300;
        if (volt < V_LO_SCALED)
            volt = V_LO_SCALED;
        if (volt > V_HI_SCALED)
            volt = V_HI_SCALED;
        a = 4 * (volt - V_LO_SCALED) - SPAN_SCALED;
        mag = (a < 0) ? -a : a;
        mag = mag * PSI_TIMES_1E8;
        q = mag / PSI_DIVISOR;
        r = mag % PSI_DIVISOR;
        if (r >= PSI_DIVISOR - r)
            q++;
        p = (a < 0) ? -int'(q) : int'(q);
        // current: clamp above mid-scale, 625 tenths of amps at full scale
        amps = 2 * longint'(cs) - FULL_SCALE;
        if (amps < 0)
            amps = 0;
        if (amps > FULL_SCALE)
            amps = FULL_SCALE;
        num = 64'd625 * amps;
        q = num / FS_U;
        r = num % FS_U;
        if (r >= FS_U - r)
            q++;
        c = int'(q);
        // events against the previous step
        rd.pressure    = p[PRESS_W-1:0];
        rd.current     = c[CUR_W-1:0];
        rd.motor_on    = (c > 0 && last_current == 0);
        rd.motor_off   = (c == 0 && last_current > 0);
        rd.press_moved = (p != last_pressure);
        rd.supply_on   = 1'b0;
        rd.supply_off  = 1'b0;
        if (p > last_pressure)
        begin
            rd.supply_off = pressurized;
        end
        else if (p < last_pressure)
        begin
            if (p == 0)
                pressurized = 1'b0;
            else
                rd.supply_on = pressurized;
        end
        else if (p > 0)
        begin
            pressurized = 1'b1;
        end
        rd.press_held = pressurized;
        last_pressure = p;
        last_current  = c;
        return rd;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result beat %0d: %s", beats_out, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input integer got, input integer want);
        if (got !== want)
            report_mismatch($sformatf("%s = %0d, expected %0d", name, got, want));
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            report_mismatch("result beat with nothing expected");
        end
        else
        begin
            want = expected_readings.pop_front();
            compare_field("pressure_tenths", pressure_tenths, want.pressure);
            compare_field("current_tenths", current_tenths, want.current);
            compare_field("motor_started", motor_started, want.motor_on);
            compare_field("motor_stopped", motor_stopped, want.motor_off);
            compare_field("pressure_changed", pressure_changed, want.press_moved);
            compare_field("supply_started", supply_started, want.supply_on);
            compare_field("supply_stopped", supply_stopped, want.supply_off);
            compare_field("pressurized_now", pressurized_now, want.press_held);
        end
    endtask

    // send one sample pair, with an optional gap before it
    task automatic send_beat(input sample_t ps, input sample_t cs, input logic typed,
                             input reading_t want);
        reading_t predicted;
        if (idle_on && $urandom_range(3, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        pressure_sample <= ps;
        current_sample  <= cs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_reading(ps, cs);
        expected_readings.push_back(typed ? want : predicted);
    endtask

    // result side: check accepted beats, count quiet cycles, random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_reading();
                beats_out++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(4, 0) == 0)
            begin
                stall_left = $urandom_range(2, 0);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int i;
        int ps_next;
        int cs_next;
        int last_ps;
        int last_cs;

        in_valid        <= 1'b0;
        pressure_sample <= '0;
        current_sample  <= '0;
        out_ready       <= 1'b0;
        rst_n           <= 1'b0;
        idle_on         <= 1'b1;
        last_pressure = 0;
        last_current  = 0;
        pressurized   = 1'b0;

        // directed plan: flags are {motor on, motor off, moved, supply on, supply off, held}
        // from reset: lowest pressure, no current
        plan[0]  = {12'd0,    12'd0,    1'b1, -10'sd145, 10'd0,   6'b001000};
        // both at full scale, motor starts
        plan[1]  = {12'd4095, 12'd4095, 1'b1, 10'sd435,  10'd625, 6'b101000};
        // steady positive pressure sets the pressurized flag
        plan[2]  = {12'd4095, 12'd4095, 1'b1, 10'sd435,  10'd625, 6'b000001};
        // motor stops
        plan[3]  = {12'd4095, 12'd0,    1'b1, 10'sd435,  10'd0,   6'b010001};
        // pressure falls while pressurized, current at an exact half tenth
        plan[4]  = {12'd2048, 12'd3072, 1'b0, 26'd0};
        // pressure rises while pressurized
        plan[5]  = {12'd3000, 12'd3072, 1'b0, 26'd0};
        // pressure falls to zero, flag clears
        plan[6]  = {12'd1241, 12'd3072, 1'b0, 26'd0};
        // steady at zero, current at mid-scale
        plan[7]  = {12'd1241, 12'd2048, 1'b0, 26'd0};
        plan[8]  = {12'd2048, 12'd2049, 1'b0, 26'd0};
        plan[9]  = {12'd2048, 12'd2050, 1'b0, 26'd0};
        // falls to a negative pressure while pressurized
        plan[10] = {12'd0,    12'd2050, 1'b0, 26'd0};
        // clamp edges of both paths
        plan[11] = {12'd413,  12'd4095, 1'b0, 26'd0};
        plan[12] = {12'd414,  12'd4095, 1'b0, 26'd0};
        plan[13] = {12'd3723, 12'd3071, 1'b0, 26'd0};
        plan[14] = {12'd3724, 12'd3071, 1'b0, 26'd0};
        plan[15] = {12'd4095, 12'd2047, 1'b0, 26'd0};
        plan[16] = {12'd2047, 12'd1,    1'b0, 26'd0};
        plan[17] = {12'd2047, 12'd4094, 1'b0, 26'd0};
        // edges of the zero-pressure band
        plan[18] = {12'd1239, 12'd4094, 1'b0, 26'd0};
        plan[19] = {12'd1243, 12'd0,    1'b0, 26'd0};
        plan[20] = {12'd1238, 12'd2730, 1'b0, 26'd0};
        plan[21] = {12'd1244, 12'd4095, 1'b0, 26'd0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < PLAN_ROWS; i++)
            send_beat(plan[i].ps, plan[i].cs, plan[i].typed, plan[i].want);

        // random part: mostly held or slowly moving values so the flags get exercised
        last_ps = 2048;
        last_cs = 3000;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
                idle_on <= (i < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(3, 0) != 0);
            // hold off until the pipeline has drained
            if (i == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                while (expected_readings.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(9, 0))
                0, 1, 2: ps_next = last_ps;
                3:       ps_next = $urandom_range(1243, 1239);
                4:       ps_next = $urandom_range(413, 0);
                5:       ps_next = $urandom_range(4095, 3724);
                6, 7:    ps_next = last_ps + int'($urandom_range(80, 0)) - 40;
                default: ps_next = $urandom_range(4095, 0);
            endcase
            if (ps_next < 0)
                ps_next = 0;
            if (ps_next > 4095)
                ps_next = 4095;
            case ($urandom_range(5, 0))
                0, 1:    cs_next = last_cs;
                2:       cs_next = $urandom_range(2049, 0);
                default: cs_next = $urandom_range(4095, 0);
            endcase
            send_beat(ps_next[11:0], cs_next[11:0], 1'b0, '0);
            last_ps = ps_next;
            last_cs = cs_next;
        end
        in_valid <= 1'b0;

        // drain, then watch for stray beats
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
